// ===== design/dtpid_pkg.sv =====
// Shared widths, codes and reset values of the dual-mode drive/turn PID unit.
package dtpid_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SCALE_W = 9;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned OUT_W   = 32;

  localparam int unsigned ERR_W   = POS_W + 1;
  localparam int unsigned DER_W   = ERR_W + 1;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned RAW_W   = 48;
  localparam int unsigned ACC_W   = 58;

  localparam int unsigned MUL_A_W = 26;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam int unsigned SUM_SPLIT = 20;
  localparam int unsigned RAW_SPLIT = 24;

  localparam int unsigned SCALE_FRAC = 8;

  localparam int unsigned DRIVE_DIV  = 12;
  localparam int unsigned PRE_SHIFT  = 2;
  localparam int unsigned REM_DIV    = DRIVE_DIV / (2 ** PRE_SHIFT);
  localparam int unsigned REM_W      = 2;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIVN_W     = ACC_W - PRE_SHIFT;
  localparam int unsigned DIV_STEPS  = DIVN_W / DIGIT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0]  DRIVE_P_RESET = GAIN_W'(141);
  localparam logic [GAIN_W-1:0]  DRIVE_I_RESET = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]  DRIVE_D_RESET = GAIN_W'(51);
  localparam logic [GAIN_W-1:0]  TURN_P_RESET  = GAIN_W'(115);
  localparam logic [GAIN_W-1:0]  TURN_I_RESET  = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]  TURN_D_RESET  = GAIN_W'(102);
  localparam logic [SCALE_W-1:0] DRIVE_SCALE_RESET = SCALE_W'(256);
  localparam logic [SCALE_W-1:0] TURN_SCALE_RESET  = SCALE_W'(205);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_BRAKE = 2'd0,
    MODE_DRIVE = 2'd1,
    MODE_TURN  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_DRIVE_P     = 3'd0,
    REG_DRIVE_I     = 3'd1,
    REG_DRIVE_D     = 3'd2,
    REG_TURN_P      = 3'd3,
    REG_TURN_I      = 3'd4,
    REG_TURN_D      = 3'd5,
    REG_DRIVE_SCALE = 3'd6,
    REG_TURN_SCALE  = 3'd7
  } reg_e;

  // Halves a sum or difference, truncating toward zero.
  function automatic logic signed [ERR_W-1:0] half_tz(input logic signed [ERR_W-1:0] s);
    logic signed [ERR_W-1:0] t;
    t = s + $signed({{(ERR_W-1){1'b0}}, s[ERR_W-1]});
    return t >>> 1;
  endfunction

endpackage

// ===== design/dual_mode_drive_turn_pid_unit.sv =====
// Top level of the dual-mode drive/turn PID unit: sequencer, shared multiplier and divider.

// One request is one control tick: four wheel encoder positions plus a drive and a turn
// target. A lone nonzero drive target runs the drive PID (left motors get +power, right
// motors -power), a lone nonzero turn target runs the turn PID (all motors get -power),
// two zero targets answer brake-hold and two nonzero targets answer no action; those two
// answers carry zero commands and leave the PID state untouched. Each request produces
// exactly one result. The unit handles one request at a time and holds in_stall_o high
// while it works. A tick is also held while its result waits for a full output register
// to drain. The single 26x17 multiplier serves the six partial products of a tick, each
// in a multiply state and an accumulate state, and the divide-by-twelve of the drive
// path retires four quotient bits per cycle. Results sit in an output register, so a
// finished result may wait on out_stall_i without losing data. Gains and scales are to
// be written through the plain write port while the unit is idle; the unit itself does
// not enforce this.
module dual_mode_drive_turn_pid_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dtpid_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [dtpid_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [dtpid_pkg::POS_W-1:0]   front_left_pos_i,
  input  logic signed [dtpid_pkg::POS_W-1:0]   front_right_pos_i,
  input  logic signed [dtpid_pkg::POS_W-1:0]   back_left_pos_i,
  input  logic signed [dtpid_pkg::POS_W-1:0]   back_right_pos_i,
  input  logic signed [dtpid_pkg::POS_W-1:0]   drive_target_i,
  input  logic signed [dtpid_pkg::POS_W-1:0]   turn_target_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           mode_o,
  output logic signed [dtpid_pkg::OUT_W-1:0]   left_command_o,
  output logic signed [dtpid_pkg::OUT_W-1:0]   right_command_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_ERR,
    ST_SUM,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_SAT,
    ST_FIN,
    ST_LOAD
  } state_e;

  // Partial products of one tick, in the order the sequencer issues them.
  typedef enum logic [2:0] {
    T_P,
    T_D,
    T_IL,
    T_IH,
    T_SL,
    T_SH
  } term_e;

  localparam logic signed [dtpid_pkg::ACC_W-1:0] ROUND_NEG =
    dtpid_pkg::ACC_W'(2 ** dtpid_pkg::SCALE_FRAC - 1);
  localparam logic [dtpid_pkg::REM_W:0] REM_DIVISOR = (dtpid_pkg::REM_W + 1)'(dtpid_pkg::REM_DIV);

  // Configuration registers.
  logic [dtpid_pkg::GAIN_W-1:0]  drive_p_q, drive_i_q, drive_d_q;
  logic [dtpid_pkg::GAIN_W-1:0]  turn_p_q, turn_i_q, turn_d_q;
  logic [dtpid_pkg::SCALE_W-1:0] drive_scale_q, turn_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_p_q     <= dtpid_pkg::DRIVE_P_RESET;
      drive_i_q     <= dtpid_pkg::DRIVE_I_RESET;
      drive_d_q     <= dtpid_pkg::DRIVE_D_RESET;
      turn_p_q      <= dtpid_pkg::TURN_P_RESET;
      turn_i_q      <= dtpid_pkg::TURN_I_RESET;
      turn_d_q      <= dtpid_pkg::TURN_D_RESET;
      drive_scale_q <= dtpid_pkg::DRIVE_SCALE_RESET;
      turn_scale_q  <= dtpid_pkg::TURN_SCALE_RESET;
    end else if (cfg_we_i) begin
      case (dtpid_pkg::reg_e'(cfg_index_i))
        dtpid_pkg::REG_DRIVE_P:     drive_p_q     <= cfg_data_i[dtpid_pkg::GAIN_W-1:0];
        dtpid_pkg::REG_DRIVE_I:     drive_i_q     <= cfg_data_i[dtpid_pkg::GAIN_W-1:0];
        dtpid_pkg::REG_DRIVE_D:     drive_d_q     <= cfg_data_i[dtpid_pkg::GAIN_W-1:0];
        dtpid_pkg::REG_TURN_P:      turn_p_q      <= cfg_data_i[dtpid_pkg::GAIN_W-1:0];
        dtpid_pkg::REG_TURN_I:      turn_i_q      <= cfg_data_i[dtpid_pkg::GAIN_W-1:0];
        dtpid_pkg::REG_TURN_D:      turn_d_q      <= cfg_data_i[dtpid_pkg::GAIN_W-1:0];
        dtpid_pkg::REG_DRIVE_SCALE: drive_scale_q <= cfg_data_i[dtpid_pkg::SCALE_W-1:0];
        dtpid_pkg::REG_TURN_SCALE:  turn_scale_q  <= cfg_data_i[dtpid_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, PID history and working registers.
  state_e                                 state_q, state_d;
  term_e                                  term_q, term_d;
  dtpid_pkg::mode_e                       mode_q, mode_d;
  logic signed [dtpid_pkg::POS_W-1:0]     fl_q, fl_d, fr_q, fr_d, bl_q, bl_d, br_q, br_d;
  logic signed [dtpid_pkg::POS_W-1:0]     tgt_q, tgt_d;
  logic signed [dtpid_pkg::ERR_W-1:0]     la_q, la_d, ra_q, ra_d;
  logic signed [dtpid_pkg::ERR_W-1:0]     err_q, err_d;
  logic signed [dtpid_pkg::DER_W-1:0]     deriv_q, deriv_d;
  logic signed [dtpid_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic signed [dtpid_pkg::ERR_W-1:0]     last_drive_q, last_drive_d;
  logic signed [dtpid_pkg::ERR_W-1:0]     last_turn_q, last_turn_d;
  logic signed [dtpid_pkg::SUM_W-1:0]     drive_sum_q, drive_sum_d;
  logic signed [dtpid_pkg::SUM_W-1:0]     turn_sum_q, turn_sum_d;
  logic signed [dtpid_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic signed [dtpid_pkg::ACC_W-1:0]     acc_q, acc_d;
  logic signed [dtpid_pkg::RAW_W-1:0]     raw_q, raw_d;
  logic [dtpid_pkg::DIVN_W-1:0]           div_q, div_d;
  logic [dtpid_pkg::REM_W-1:0]            rem_q, rem_d;
  logic [dtpid_pkg::DIV_CNT_W-1:0]        cnt_q, cnt_d;
  logic                                   neg_q, neg_d;
  logic signed [dtpid_pkg::OUT_W-1:0]     res_left_q, res_left_d;
  logic signed [dtpid_pkg::OUT_W-1:0]     res_right_q, res_right_d;
  logic                                   out_valid_q, out_valid_d;
  dtpid_pkg::mode_e                       out_mode_q, out_mode_d;
  logic signed [dtpid_pkg::OUT_W-1:0]     out_left_q, out_left_d;
  logic signed [dtpid_pkg::OUT_W-1:0]     out_right_q, out_right_d;

  logic                                   is_drive;
  logic                                   in_fire;
  logic                                   out_free;
  logic signed [dtpid_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [dtpid_pkg::MUL_B_W-1:0]   mul_b;
  logic [dtpid_pkg::GAIN_W-1:0]           gain_p, gain_i, gain_d;
  logic [dtpid_pkg::SCALE_W-1:0]          scale_sel;

  assign is_drive   = (mode_q == dtpid_pkg::MODE_DRIVE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign gain_p    = is_drive ? drive_p_q : turn_p_q;
  assign gain_i    = is_drive ? drive_i_q : turn_i_q;
  assign gain_d    = is_drive ? drive_d_q : turn_d_q;
  assign scale_sel = is_drive ? drive_scale_q : turn_scale_q;

  // Operand selection for the one shared multiplier. Wide operands are split into a
  // signed upper part and an unsigned lower part, recombined by a shift at accumulate.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (term_q)
      T_P: begin
        mul_a = dtpid_pkg::MUL_A_W'(err_q);
        mul_b = $signed({1'b0, gain_p});
      end
      T_D: begin
        mul_a = dtpid_pkg::MUL_A_W'(deriv_q);
        mul_b = $signed({1'b0, gain_d});
      end
      T_IL: begin
        mul_a = $signed({{(dtpid_pkg::MUL_A_W-dtpid_pkg::SUM_SPLIT){1'b0}},
                         sum_q[dtpid_pkg::SUM_SPLIT-1:0]});
        mul_b = $signed({1'b0, gain_i});
      end
      T_IH: begin
        mul_a = dtpid_pkg::MUL_A_W'($signed(sum_q[dtpid_pkg::SUM_W-1:dtpid_pkg::SUM_SPLIT]));
        mul_b = $signed({1'b0, gain_i});
      end
      T_SL: begin
        mul_a = $signed({{(dtpid_pkg::MUL_A_W-dtpid_pkg::RAW_SPLIT){1'b0}},
                         raw_q[dtpid_pkg::RAW_SPLIT-1:0]});
        mul_b = $signed({{(dtpid_pkg::MUL_B_W-dtpid_pkg::SCALE_W){1'b0}}, scale_sel});
      end
      T_SH: begin
        mul_a = dtpid_pkg::MUL_A_W'($signed(raw_q[dtpid_pkg::RAW_W-1:dtpid_pkg::RAW_SPLIT]));
        mul_b = $signed({{(dtpid_pkg::MUL_B_W-dtpid_pkg::SCALE_W){1'b0}}, scale_sel});
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Next-state logic of the sequencer.
  always_comb begin
    logic signed [dtpid_pkg::SUM_W:0]     sum_wide;
    logic signed [dtpid_pkg::ERR_W-1:0]   last_sel;
    logic signed [dtpid_pkg::SUM_W-1:0]   sum_sel;
    logic signed [dtpid_pkg::ACC_W-1:0]   addend;
    logic signed [dtpid_pkg::ACC_W-1:0]   absv;
    logic signed [dtpid_pkg::ACC_W-1:0]   quot;
    logic signed [dtpid_pkg::ACC_W-1:0]   rounded;
    logic signed [dtpid_pkg::ACC_W-1:0]   shifted;
    logic signed [dtpid_pkg::OUT_W-1:0]   scaled;
    logic signed [dtpid_pkg::OUT_W-1:0]   negated;
    logic [dtpid_pkg::DIVN_W-1:0]         dv;
    logic [dtpid_pkg::REM_W-1:0]          rm;
    logic [dtpid_pkg::REM_W:0]            trial;

    state_d      = state_q;
    term_d       = term_q;
    mode_d       = mode_q;
    fl_d         = fl_q;
    fr_d         = fr_q;
    bl_d         = bl_q;
    br_d         = br_q;
    tgt_d        = tgt_q;
    la_d         = la_q;
    ra_d         = ra_q;
    err_d        = err_q;
    deriv_d      = deriv_q;
    sum_d        = sum_q;
    last_drive_d = last_drive_q;
    last_turn_d  = last_turn_q;
    drive_sum_d  = drive_sum_q;
    turn_sum_d   = turn_sum_q;
    acc_d        = acc_q;
    raw_d        = raw_q;
    div_d        = div_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_mode_d   = out_mode_q;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;

    last_sel = is_drive ? last_drive_q : last_turn_q;
    sum_sel  = is_drive ? drive_sum_q : turn_sum_q;
    sum_wide = (dtpid_pkg::SUM_W+1)'(sum_sel) + (dtpid_pkg::SUM_W+1)'(err_q);

    addend = dtpid_pkg::ACC_W'(prod_q);
    if (term_q == T_IH) begin
      addend = addend <<< dtpid_pkg::SUM_SPLIT;
    end else if (term_q == T_SH) begin
      addend = addend <<< dtpid_pkg::RAW_SPLIT;
    end

    absv    = acc_q[dtpid_pkg::ACC_W-1] ? -acc_q : acc_q;
    quot    = dtpid_pkg::ACC_W'(div_q);
    rounded = acc_q + (acc_q[dtpid_pkg::ACC_W-1] ? ROUND_NEG : '0);
    shifted = rounded >>> dtpid_pkg::SCALE_FRAC;
    if ((shifted[dtpid_pkg::ACC_W-1:dtpid_pkg::OUT_W-1] == '0) ||
        (shifted[dtpid_pkg::ACC_W-1:dtpid_pkg::OUT_W-1] == '1)) begin
      scaled = shifted[dtpid_pkg::OUT_W-1:0];
    end else begin
      scaled = shifted[dtpid_pkg::ACC_W-1] ? dtpid_pkg::OUT_MIN : dtpid_pkg::OUT_MAX;
    end
    negated = (scaled == dtpid_pkg::OUT_MIN) ? dtpid_pkg::OUT_MAX : -scaled;

    // Four long-division steps by three; quotient bits shift in as dividend bits leave.
    dv = div_q;
    rm = rem_q;
    for (int i = 0; i < dtpid_pkg::DIGIT_W; i++) begin
      trial = {rm, dv[dtpid_pkg::DIVN_W-1]};
      dv    = {dv[dtpid_pkg::DIVN_W-2:0], 1'b0};
      if (trial >= REM_DIVISOR) begin
        trial = trial - REM_DIVISOR;
        dv[0] = 1'b1;
      end
      rm = trial[dtpid_pkg::REM_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          fl_d        = front_left_pos_i;
          fr_d        = front_right_pos_i;
          bl_d        = back_left_pos_i;
          br_d        = back_right_pos_i;
          res_left_d  = '0;
          res_right_d = '0;
          if (drive_target_i != '0 && turn_target_i == '0) begin
            mode_d  = dtpid_pkg::MODE_DRIVE;
            tgt_d   = drive_target_i;
            state_d = ST_AVG;
          end else if (drive_target_i == '0 && turn_target_i != '0) begin
            mode_d  = dtpid_pkg::MODE_TURN;
            tgt_d   = turn_target_i;
            state_d = ST_AVG;
          end else if (drive_target_i == '0) begin
            mode_d  = dtpid_pkg::MODE_BRAKE;
            state_d = ST_LOAD;
          end else begin
            mode_d  = dtpid_pkg::MODE_NONE;
            state_d = ST_LOAD;
          end
        end
      end
      ST_AVG: begin
        if (is_drive) begin
          la_d = dtpid_pkg::half_tz(dtpid_pkg::ERR_W'(fl_q) + dtpid_pkg::ERR_W'(bl_q));
          ra_d = dtpid_pkg::half_tz(dtpid_pkg::ERR_W'(fr_q) + dtpid_pkg::ERR_W'(br_q));
        end else begin
          la_d = '0;
          ra_d = dtpid_pkg::half_tz(dtpid_pkg::ERR_W'(fl_q) + dtpid_pkg::ERR_W'(fr_q));
        end
        state_d = ST_ERR;
      end
      ST_ERR: begin
        if (is_drive) begin
          err_d = dtpid_pkg::half_tz(ra_q - la_q) - dtpid_pkg::ERR_W'(tgt_q);
        end else begin
          err_d = ra_q - dtpid_pkg::ERR_W'(tgt_q);
        end
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // The integral saturates to 40 bits; the history of the running PID is updated.
        if (sum_wide[dtpid_pkg::SUM_W] != sum_wide[dtpid_pkg::SUM_W-1]) begin
          sum_d = sum_wide[dtpid_pkg::SUM_W] ? {1'b1, {(dtpid_pkg::SUM_W-1){1'b0}}}
                                             : {1'b0, {(dtpid_pkg::SUM_W-1){1'b1}}};
        end else begin
          sum_d = sum_wide[dtpid_pkg::SUM_W-1:0];
        end
        deriv_d = dtpid_pkg::DER_W'(err_q) - dtpid_pkg::DER_W'(last_sel);
        if (is_drive) begin
          last_drive_d = err_q;
          drive_sum_d  = sum_d;
        end else begin
          last_turn_d = err_q;
          turn_sum_d  = sum_d;
        end
        acc_d   = '0;
        term_d  = T_P;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + addend;
        if (term_q == T_IH) begin
          state_d = is_drive ? ST_DIV_INIT : ST_SAT;
        end else if (term_q == T_SH) begin
          state_d = ST_FIN;
        end else begin
          term_d  = term_e'(term_q + 3'd1);
          state_d = ST_MUL;
        end
      end
      ST_DIV_INIT: begin
        // Divide by twelve: drop two bits of the magnitude, then divide by three.
        neg_d   = acc_q[dtpid_pkg::ACC_W-1];
        div_d   = absv[dtpid_pkg::ACC_W-1:dtpid_pkg::PRE_SHIFT];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_d = dv;
        rem_d = rm;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dtpid_pkg::DIV_CNT_W'(dtpid_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        acc_d   = neg_q ? -quot : quot;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if ((acc_q[dtpid_pkg::ACC_W-1:dtpid_pkg::RAW_W-1] == '0) ||
            (acc_q[dtpid_pkg::ACC_W-1:dtpid_pkg::RAW_W-1] == '1)) begin
          raw_d = acc_q[dtpid_pkg::RAW_W-1:0];
        end else begin
          raw_d = acc_q[dtpid_pkg::ACC_W-1] ? {1'b1, {(dtpid_pkg::RAW_W-1){1'b0}}}
                                            : {1'b0, {(dtpid_pkg::RAW_W-1){1'b1}}};
        end
        acc_d   = '0;
        term_d  = T_SL;
        state_d = ST_MUL;
      end
      ST_FIN: begin
        if (is_drive) begin
          res_left_d  = scaled;
          res_right_d = negated;
        end else begin
          res_left_d  = negated;
          res_right_d = negated;
        end
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mode_d  = mode_q;
          out_left_d  = res_left_q;
          out_right_d = res_right_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      term_q       <= T_P;
      mode_q       <= dtpid_pkg::MODE_BRAKE;
      fl_q         <= '0;
      fr_q         <= '0;
      bl_q         <= '0;
      br_q         <= '0;
      tgt_q        <= '0;
      la_q         <= '0;
      ra_q         <= '0;
      err_q        <= '0;
      deriv_q      <= '0;
      sum_q        <= '0;
      last_drive_q <= '0;
      last_turn_q  <= '0;
      drive_sum_q  <= '0;
      turn_sum_q   <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      raw_q        <= '0;
      div_q        <= '0;
      rem_q        <= '0;
      cnt_q        <= '0;
      neg_q        <= 1'b0;
      res_left_q   <= '0;
      res_right_q  <= '0;
      out_valid_q  <= 1'b0;
      out_mode_q   <= dtpid_pkg::MODE_BRAKE;
      out_left_q   <= '0;
      out_right_q  <= '0;
    end else begin
      state_q      <= state_d;
      term_q       <= term_d;
      mode_q       <= mode_d;
      fl_q         <= fl_d;
      fr_q         <= fr_d;
      bl_q         <= bl_d;
      br_q         <= br_d;
      tgt_q        <= tgt_d;
      la_q         <= la_d;
      ra_q         <= ra_d;
      err_q        <= err_d;
      deriv_q      <= deriv_d;
      sum_q        <= sum_d;
      last_drive_q <= last_drive_d;
      last_turn_q  <= last_turn_d;
      drive_sum_q  <= drive_sum_d;
      turn_sum_q   <= turn_sum_d;
      prod_q       <= prod_d;
      acc_q        <= acc_d;
      raw_q        <= raw_d;
      div_q        <= div_d;
      rem_q        <= rem_d;
      cnt_q        <= cnt_d;
      neg_q        <= neg_d;
      res_left_q   <= res_left_d;
      res_right_q  <= res_right_d;
      out_valid_q  <= out_valid_d;
      out_mode_q   <= out_mode_d;
      out_left_q   <= out_left_d;
      out_right_q  <= out_right_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = out_mode_q;
  assign left_command_o  = out_left_q;
  assign right_command_o = out_right_q;

  // Only one request is in flight: acceptance always closes the input side next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a request was still in progress");

  // Brake-hold and no-action results carry zero commands.
  a_idle_modes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == dtpid_pkg::MODE_BRAKE || mode_o == dtpid_pkg::MODE_NONE)
    |-> left_command_o == '0 && right_command_o == '0)
    else $error("brake or no-action result with nonzero commands");

  // A turn drives both sides with the same command.
  a_turn_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == dtpid_pkg::MODE_TURN |-> left_command_o == right_command_o)
    else $error("turn result with unequal side commands");

  // A drive move commands the right side with the saturated negation of the left.
  a_drive_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == dtpid_pkg::MODE_DRIVE
    |-> right_command_o == ((left_command_o == dtpid_pkg::OUT_MIN) ?
                            dtpid_pkg::OUT_MAX : -left_command_o))
    else $error("drive result sides are not mirrored");

endmodule
